// ===== hdl/plrg_pkg.sv =====
// plrg_pkg: shared constants, command codes and state types for the ramp generator
// no dependencies; imported by every other file of the block

package plrg_pkg;

    // default widths
    localparam int VALUE_BITS_DEF = 32;
    localparam int TIME_BITS_DEF  = 24;

    // command field width and grain fallback
    localparam int MODE_BITS      = 3;
    localparam int GRAIN_BITS     = 16;
    localparam int DEFAULT_GRAIN  = 20;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRAIN_TICKS    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FREEZE_ON_STOP = 1'd1;

    // result kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // command codes
    typedef enum logic [MODE_BITS-1:0] {
        MODE_TICK  = 3'd0,
        MODE_GO    = 3'd1,
        MODE_SET   = 3'd2,
        MODE_STOP  = 3'd3,
        MODE_PAUSE = 3'd4
    } mode_t;

    // command sequencer states
    typedef enum logic [1:0] {
        C_IDLE,
        C_EXEC,
        C_WAIT,
        C_EMIT
    } ctrl_state_t;

    // interpolation unit states
    typedef enum logic [2:0] {
        IU_IDLE,
        IU_MUL,
        IU_DIV,
        IU_ADJ,
        IU_DONE
    } iu_state_t;

endpackage

// ===== hdl/plrg_cmd_if.sv =====
// plrg_cmd_if: command channel, valid/ready with mode, value and ramp time
// depends on plrg_pkg

interface plrg_cmd_if
    import plrg_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [MODE_BITS-1:0]         mode;
    logic signed [VALUE_BITS-1:0] value;
    logic [TIME_BITS-1:0]         ramp_ticks;

    modport source (output valid, mode, value, ramp_ticks, input ready);
    modport sink   (input valid, mode, value, ramp_ticks, output ready);
endinterface

// ===== hdl/plrg_res_if.sv =====
// plrg_res_if: result channel, valid/ready with kind, value, status and last
// depends on plrg_pkg

interface plrg_res_if
    import plrg_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         out_kind;
    logic signed [VALUE_BITS-1:0] out_value;
    logic                         status_bit;
    logic                         last;

    modport source (output valid, out_kind, out_value, status_bit, last, input ready);
    modport sink   (input valid, out_kind, out_value, status_bit, last, output ready);
endinterface

// ===== hdl/pausable_linear_ramp_generator_unit.sv =====
// pausable_linear_ramp_generator_unit: ramp generator top level
// sequence: each command is decoded in C_EXEC, then waits in C_WAIT when it
// needs the interpolated value (bit-serial multiply and divide in plrg_interp_unit)
// throughput: one command at a time; a new command is accepted only once the
// results of the last one have been delivered on the result channel
// reset: segment cleared (length one, inactive), grain 20 ticks, freeze on stop set

module pausable_linear_ramp_generator_unit
    import plrg_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    plrg_cmd_if.sink                  cmd,
    plrg_res_if.source                res,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);
    logic                  iu_go;
    logic [VALUE_BITS-1:0] iu_start;
    logic [VALUE_BITS-1:0] iu_target;
    logic [TIME_BITS-1:0]  iu_elapsed;
    logic [TIME_BITS-1:0]  iu_length;
    logic                  iu_done;
    logic [VALUE_BITS-1:0] iu_result;

    // command sequencer
    plrg_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .iu_go      (iu_go),
        .iu_start   (iu_start),
        .iu_target  (iu_target),
        .iu_elapsed (iu_elapsed),
        .iu_length  (iu_length),
        .iu_done    (iu_done),
        .iu_result  (iu_result)
    );

    // shared interpolation unit
    plrg_interp_unit #(
        .VALUE_BITS (VALUE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (iu_go),
        .start_value  (iu_start),
        .target_value (iu_target),
        .elapsed      (iu_elapsed),
        .length       (iu_length),
        .done         (iu_done),
        .result       (iu_result)
    );

endmodule

// ===== hdl/plrg_interp_unit.sv =====
// plrg_interp_unit: iterative start + trunc(elapsed*(target-start)/length)
// shift-add multiply then restoring divide, one bit per cycle; depends on plrg_pkg

module plrg_interp_unit
    import plrg_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [VALUE_BITS-1:0] start_value,
    input  logic [VALUE_BITS-1:0] target_value,
    input  logic [TIME_BITS-1:0]  elapsed,
    input  logic [TIME_BITS-1:0]  length,
    output logic                  done,
    output logic [VALUE_BITS-1:0] result
);
    localparam int MAXB = (VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS;
    localparam int CW   = $clog2(MAXB + 1);
    localparam int PW   = VALUE_BITS + TIME_BITS;

    iu_state_t              state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0]  start_reg, start_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [TIME_BITS-1:0]   mplier_reg, mplier_next;
    logic [TIME_BITS-1:0]   len_reg, len_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [TIME_BITS-1:0]   rem_reg, rem_next;
    logic [VALUE_BITS-1:0]  result_reg, result_next;

    logic [VALUE_BITS:0]    diff;
    logic [VALUE_BITS:0]    diff_abs;
    logic                   trivial;
    logic [PW-1:0]          prod_step;
    logic [TIME_BITS:0]     trial;
    logic                   qbit;
    logic                   last_step;

    // operand preparation
    always_comb
    begin
        diff     = {target_value[VALUE_BITS-1], target_value}
                 - {start_value[VALUE_BITS-1], start_value};
        diff_abs = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;
        trivial  = (length == '0) || (elapsed >= length);
    end

    // shared step datapath
    always_comb
    begin
        prod_step = {prod_reg[PW-2:0], 1'b0}
                  + (mplier_reg[TIME_BITS-1] ? PW'(mag_reg) : '0);
        trial     = {rem_reg, prod_reg[VALUE_BITS-1]};
        qbit      = (trial >= {1'b0, len_reg});
        last_step = (cnt_reg == CW'(1));
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IU_IDLE: if (go) state_next = trivial ? IU_DONE : IU_MUL;
            IU_MUL:  if (last_step) state_next = IU_DIV;
            IU_DIV:  if (last_step) state_next = IU_ADJ;
            IU_ADJ:  state_next = IU_DONE;
            IU_DONE: state_next = IU_IDLE;
            default: state_next = IU_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        cnt_next    = cnt_reg;
        start_next  = start_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        mplier_next = mplier_reg;
        len_next    = len_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        result_next = result_reg;
        case (state_reg)
            IU_IDLE:
            begin
                if (go)
                begin
                    start_next  = start_value;
                    neg_next    = diff[VALUE_BITS];
                    mag_next    = diff_abs[VALUE_BITS-1:0];
                    mplier_next = elapsed;
                    len_next    = length;
                    prod_next   = '0;
                    cnt_next    = CW'(TIME_BITS);
                    result_next = target_value;
                end
            end
            IU_MUL:
            begin
                prod_next   = prod_step;
                mplier_next = {mplier_reg[TIME_BITS-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (last_step)
                begin
                    rem_next = prod_step[PW-1:VALUE_BITS];
                    cnt_next = CW'(VALUE_BITS);
                end
            end
            IU_DIV:
            begin
                rem_next  = qbit ? TIME_BITS'(trial - {1'b0, len_reg}) : TIME_BITS'(trial);
                prod_next = {prod_reg[PW-1:VALUE_BITS], prod_reg[VALUE_BITS-2:0], qbit};
                cnt_next  = cnt_reg - 1'b1;
            end
            IU_ADJ:
            begin
                result_next = neg_reg ? (start_reg - prod_reg[VALUE_BITS-1:0])
                                      : (start_reg + prod_reg[VALUE_BITS-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        mplier_reg <= mplier_next;
        len_reg    <= len_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        result_reg <= result_next;
    end

    assign done   = (state_reg == IU_DONE);
    assign result = result_reg;

endmodule

// ===== hdl/plrg_ctrl.sv =====
// plrg_ctrl: command sequencer, ramp segment state, config registers, result buffer
// depends on plrg_pkg, plrg_cmd_if, plrg_res_if; drives plrg_interp_unit

module plrg_ctrl
    import plrg_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    plrg_cmd_if.sink                  cmd,
    plrg_res_if.source                res,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                      iu_go,
    output logic [VALUE_BITS-1:0]     iu_start,
    output logic [VALUE_BITS-1:0]     iu_target,
    output logic [TIME_BITS-1:0]      iu_elapsed,
    output logic [TIME_BITS-1:0]      iu_length,
    input  logic                      iu_done,
    input  logic [VALUE_BITS-1:0]     iu_result
);
    localparam int GW = (TIME_BITS > GRAIN_BITS) ? TIME_BITS : GRAIN_BITS;

    typedef struct packed {
        logic                  kind;
        logic [VALUE_BITS-1:0] value;
        logic                  status;
    } result_t;

    ctrl_state_t            state_reg, state_next;
    logic [MODE_BITS-1:0]   mode_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [TIME_BITS-1:0]   ramp_reg;
    logic [GRAIN_BITS-1:0]  grain_reg;
    logic                   freeze_reg;

    logic [VALUE_BITS-1:0]  start_reg, start_next;
    logic [VALUE_BITS-1:0]  target_reg, target_next;
    logic [TIME_BITS-1:0]   length_reg, length_next;
    logic [TIME_BITS-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]   count_reg, count_next;
    logic                   active_reg, active_next;
    logic                   paused_reg, paused_next;

    result_t                res_reg [2];
    result_t                res_next [2];
    logic [1:0]             n_reg, n_next;
    logic                   idx_reg;

    logic                   running;
    logic [TIME_BITS-1:0]   e_inc;
    logic [TIME_BITS-1:0]   rem_tick;
    logic [TIME_BITS-1:0]   rem_pause;
    logic                   fires;
    logic                   need_i;
    logic                   apply;
    logic [VALUE_BITS-1:0]  cur;
    logic                   accept;
    logic                   res_last;

    // min(grain, limit) with a zero grain meaning the default
    function automatic logic [TIME_BITS-1:0] grain_clip(
        input logic [GRAIN_BITS-1:0] grain,
        input logic [TIME_BITS-1:0]  limit
    );
        logic [GW-1:0] g;
        logic [GW-1:0] l;
        g = (grain == '0) ? GW'(DEFAULT_GRAIN) : GW'(grain);
        l = GW'(limit);
        grain_clip = (g > l) ? TIME_BITS'(l) : TIME_BITS'(g);
    endfunction

    // segment status terms
    always_comb
    begin
        running   = active_reg && !paused_reg;
        e_inc     = (elapsed_reg < length_reg) ? elapsed_reg + 1'b1 : elapsed_reg;
        rem_tick  = length_reg - e_inc;
        rem_pause = (length_reg > elapsed_reg) ? length_reg - elapsed_reg : '0;
        fires     = (count_reg <= TIME_BITS'(1));
    end

    // does this command need the interpolated value
    always_comb
    begin
        case (mode_reg)
            MODE_TICK:  need_i = running && fires && (rem_tick != '0);
            MODE_GO:    need_i = (ramp_reg != '0) && running;
            MODE_STOP:  need_i = freeze_reg && running;
            MODE_PAUSE: need_i = (start_reg != target_reg) && running;
            default:    need_i = 1'b0;
        endcase
    end

    // interpolation unit request
    assign iu_go      = (state_reg == C_EXEC) && need_i;
    assign iu_start   = start_reg;
    assign iu_target  = target_reg;
    assign iu_elapsed = (mode_reg == MODE_TICK) ? e_inc : elapsed_reg;
    assign iu_length  = length_reg;

    assign apply = ((state_reg == C_EXEC) && !need_i) || ((state_reg == C_WAIT) && iu_done);
    assign cur   = running ? iu_result : start_reg;

    // command execution: next segment state and results
    always_comb
    begin
        start_next   = start_reg;
        target_next  = target_reg;
        length_next  = length_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        active_next  = active_reg;
        paused_next  = paused_reg;
        res_next[0]  = '{kind: KIND_VALUE, value: '0, status: 1'b0};
        res_next[1]  = '{kind: KIND_VALUE, value: '0, status: 1'b0};
        n_next       = 2'd0;
        case (mode_reg)
            MODE_TICK:
            begin
                if (running)
                begin
                    elapsed_next = e_inc;
                    if (!fires)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else if (rem_tick == '0)
                    begin
                        res_next[0] = '{kind: KIND_STATUS, value: '0, status: 1'b0};
                        res_next[1] = '{kind: KIND_VALUE, value: target_reg, status: 1'b0};
                        n_next      = 2'd2;
                        start_next  = target_reg;
                        active_next = 1'b0;
                        count_next  = '0;
                    end
                    else
                    begin
                        res_next[0] = '{kind: KIND_VALUE, value: iu_result, status: 1'b0};
                        n_next      = 2'd1;
                        count_next  = grain_clip(grain_reg, rem_tick);
                    end
                end
            end
            MODE_GO:
            begin
                if (ramp_reg != '0)
                begin
                    start_next   = cur;
                    target_next  = val_reg;
                    length_next  = ramp_reg;
                    elapsed_next = '0;
                    count_next   = grain_clip(grain_reg, ramp_reg);
                    active_next  = 1'b1;
                    paused_next  = 1'b0;
                    res_next[0]  = '{kind: KIND_VALUE, value: cur, status: 1'b0};
                    res_next[1]  = '{kind: KIND_STATUS, value: '0, status: 1'b1};
                    n_next       = 2'd2;
                end
                else
                begin
                    start_next  = val_reg;
                    target_next = val_reg;
                    active_next = 1'b0;
                    paused_next = 1'b0;
                    count_next  = '0;
                    res_next[0] = '{kind: KIND_VALUE, value: val_reg, status: 1'b0};
                    n_next      = 2'd1;
                end
            end
            MODE_SET:
            begin
                start_next  = val_reg;
                target_next = val_reg;
                active_next = 1'b0;
                paused_next = 1'b0;
                count_next  = '0;
            end
            MODE_STOP:
            begin
                if (freeze_reg)
                begin
                    start_next  = cur;
                    target_next = cur;
                    active_next = 1'b0;
                    count_next  = '0;
                end
                else
                begin
                    target_next = start_reg;
                    if (paused_reg)
                    begin
                        active_next = 1'b0;
                    end
                end
                paused_next = 1'b0;
                res_next[0] = '{kind: KIND_STATUS, value: '0, status: 1'b0};
                n_next      = 2'd1;
            end
            MODE_PAUSE:
            begin
                if (start_reg != target_reg)
                begin
                    res_next[0]  = '{kind: KIND_STATUS, value: '0, status: paused_reg};
                    n_next       = 2'd1;
                    paused_next  = !paused_reg;
                    elapsed_next = '0;
                    if (!paused_reg)
                    begin
                        // re-base the segment on the remaining time
                        start_next  = active_reg ? iu_result : start_reg;
                        length_next = rem_pause;
                        count_next  = '0;
                    end
                    else
                    begin
                        count_next = grain_clip(grain_reg, length_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE: if (cmd.valid) state_next = C_EXEC;
            C_EXEC:
            begin
                if (need_i)
                    state_next = C_WAIT;
                else
                    state_next = (n_next != 2'd0) ? C_EMIT : C_IDLE;
            end
            C_WAIT:
            begin
                if (iu_done)
                    state_next = (n_next != 2'd0) ? C_EMIT : C_IDLE;
            end
            C_EMIT: if (res.ready && res_last) state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // channel outputs
    always_comb
    begin
        cmd.ready      = (state_reg == C_IDLE);
        res.valid      = (state_reg == C_EMIT);
        res_last       = (({1'b0, idx_reg} + 2'd1) == n_reg);
        res.out_kind   = res_reg[idx_reg].kind;
        res.out_value  = res_reg[idx_reg].value;
        res.status_bit = res_reg[idx_reg].status;
        res.last       = res_last;
    end

    assign accept = cmd.valid && (state_reg == C_IDLE);

    // control and segment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            grain_reg   <= GRAIN_BITS'(DEFAULT_GRAIN);
            freeze_reg  <= 1'b1;
            start_reg   <= '0;
            target_reg  <= '0;
            length_reg  <= TIME_BITS'(1);
            elapsed_reg <= '0;
            count_reg   <= '0;
            active_reg  <= 1'b0;
            paused_reg  <= 1'b0;
            n_reg       <= 2'd0;
            idx_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRAIN_TICKS:    grain_reg  <= cfg_data[GRAIN_BITS-1:0];
                    CFG_FREEZE_ON_STOP: freeze_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (apply)
            begin
                start_reg   <= start_next;
                target_reg  <= target_next;
                length_reg  <= length_next;
                elapsed_reg <= elapsed_next;
                count_reg   <= count_next;
                active_reg  <= active_next;
                paused_reg  <= paused_next;
                n_reg       <= n_next;
                idx_reg     <= 1'b0;
            end
            else if (res.valid && res.ready)
            begin
                idx_reg <= !idx_reg;
            end
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= cmd.mode;
            val_reg  <= cmd.value;
            ramp_reg <= cmd.ramp_ticks;
        end
        if (apply)
        begin
            res_reg[0] <= res_next[0];
            res_reg[1] <= res_next[1];
        end
    end

endmodule
